>>> hdl/stdp_pkg.sv
package stdp_pkg;

    // Item kinds carried in s_tuser.
    localparam logic [1:0] KIND_PRE   = 2'd0;
    localparam logic [1:0] KIND_POST  = 2'd1;
    localparam logic [1:0] KIND_APPLY = 2'd2;
    localparam logic [1:0] KIND_LOAD  = 2'd3;

    // Configuration register indexes.
    localparam logic [2:0] CFG_TAU_PLUS    = 3'd0;
    localparam logic [2:0] CFG_TAU_MINUS   = 3'd1;
    localparam logic [2:0] CFG_DECAY_PLUS  = 3'd2;
    localparam logic [2:0] CFG_DECAY_MINUS = 3'd3;
    localparam logic [2:0] CFG_GAIN_PLUS   = 3'd4;
    localparam logic [2:0] CFG_GAIN_MINUS  = 3'd5;

    localparam logic [5:0]  TAU_RESET   = 6'd16;
    localparam logic [15:0] DECAY_RESET = 16'd61565;
    localparam logic [15:0] GAIN_RESET  = 16'd4096;

    localparam int ACC_W = 48;

    typedef struct packed {
        logic capture;
        logic rd;
        logic decide;
        logic spike_wr;
        logic load_wr;
        logic pair_init;
        logic pair_rd;
        logic pow_init;
        logic pow_step;
        logic mul;
        logic acc;
        logic finish;
        logic emit;
    } stdp_cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       in_range;
        logic       spike_ok;
        logic       both_full;
        logic       pairs_empty;
        logic       pow_done;
        logic       last_pair;
        logic       out_free;
    } stdp_status_t;

endpackage

>>> hdl/stdp_ctrl.sv
module stdp_ctrl
    import stdp_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  stdp_status_t status,
    output stdp_cmd_t    cmd
);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_READ    = 4'd1;
    localparam logic [3:0] ST_DEC     = 4'd2;
    localparam logic [3:0] ST_PAIR_RD = 4'd3;
    localparam logic [3:0] ST_PAIR_D  = 4'd4;
    localparam logic [3:0] ST_POW     = 4'd5;
    localparam logic [3:0] ST_MUL     = 4'd6;
    localparam logic [3:0] ST_ACC     = 4'd7;
    localparam logic [3:0] ST_FIN     = 4'd8;
    localparam logic [3:0] ST_EMIT    = 4'd9;

    logic [3:0] state_reg, state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_READ;
                end
            end
            ST_READ: begin
                cmd.rd     = 1'b1;
                state_next = ST_DEC;
            end
            ST_DEC: begin
                cmd.decide = 1'b1;
                state_next = ST_EMIT;
                if (status.in_range) begin
                    case (status.kind)
                        KIND_PRE, KIND_POST: cmd.spike_wr = status.spike_ok;
                        KIND_LOAD:           cmd.load_wr  = 1'b1;
                        KIND_APPLY: begin
                            if (status.both_full) begin
                                cmd.pair_init = 1'b1;
                                state_next = status.pairs_empty ? ST_FIN : ST_PAIR_RD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_PAIR_RD: begin
                cmd.pair_rd = 1'b1;
                state_next  = ST_PAIR_D;
            end
            ST_PAIR_D: begin
                cmd.pow_init = 1'b1;
                state_next   = ST_POW;
            end
            ST_POW: begin
                if (status.pow_done) begin
                    state_next = ST_MUL;
                end else begin
                    cmd.pow_step = 1'b1;
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC: begin
                cmd.acc    = 1'b1;
                state_next = status.last_pair ? ST_FIN : ST_PAIR_RD;
            end
            ST_FIN: begin
                cmd.finish = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

>>> hdl/stdp_dp.sv
module stdp_dp
    import stdp_pkg::*;
#(
    parameter int SYNAPSES  = 256,
    parameter int MAX_QUEUE = 64
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  stdp_cmd_t    cmd,
    output stdp_status_t status,
    input  logic [71:0]  s_tdata,
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [39:0]  m_tdata,
    output logic [2:0]   m_tuser,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [15:0]  cfg_data
);

    localparam int SW = (SYNAPSES > 1) ? $clog2(SYNAPSES) : 1;
    localparam int QW = $clog2(MAX_QUEUE);
    localparam int CW = $clog2(MAX_QUEUE + 1);
    localparam int QDEPTH = SYNAPSES << QW;

    // Configuration registers.
    logic [5:0]         tau_plus_reg, tau_minus_reg;
    logic [15:0]        decay_plus_reg, decay_minus_reg;
    logic signed [15:0] gain_plus_reg, gain_minus_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tau_plus_reg    <= TAU_RESET;
            tau_minus_reg   <= TAU_RESET;
            decay_plus_reg  <= DECAY_RESET;
            decay_minus_reg <= DECAY_RESET;
            gain_plus_reg   <= GAIN_RESET;
            gain_minus_reg  <= GAIN_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_TAU_PLUS:    tau_plus_reg    <= cfg_data[5:0];
                CFG_TAU_MINUS:   tau_minus_reg   <= cfg_data[5:0];
                CFG_DECAY_PLUS:  decay_plus_reg  <= cfg_data;
                CFG_DECAY_MINUS: decay_minus_reg <= cfg_data;
                CFG_GAIN_PLUS:   gain_plus_reg   <= cfg_data;
                CFG_GAIN_MINUS:  gain_minus_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    logic [6:0]    tau_sum;
    logic [CW-1:0] lim;
    assign tau_sum = {1'b0, tau_plus_reg} + {1'b0, tau_minus_reg};
    assign lim = (tau_sum > 7'(MAX_QUEUE)) ? CW'(MAX_QUEUE) : CW'(tau_sum);

    // Captured item.
    logic [1:0]  kind_reg;
    logic [7:0]  syn_reg;
    logic [31:0] time_reg;
    logic [31:0] win_reg;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            kind_reg <= s_tuser;
            syn_reg  <= s_tdata[7:0];
            time_reg <= s_tdata[39:8];
            win_reg  <= s_tdata[71:40];
        end
    end

    logic [SW-1:0] syn_idx;
    logic          in_range;
    assign syn_idx  = SW'(syn_reg);
    assign in_range = ({24'd0, syn_reg} < 32'(SYNAPSES));

    // Storage: queue counts (with valid bits cleared at reset), weights, spike times.
    logic [2*CW-1:0] cnt_mem [SYNAPSES];
    logic [SYNAPSES-1:0] cnt_vld_reg;
    logic [31:0]     w_mem [SYNAPSES];
    logic [31:0]     pre_mem [QDEPTH];
    logic [31:0]     post_mem [QDEPTH];

    logic [2*CW-1:0] cnt_rd_reg;
    logic            cnt_vld_rd_reg;
    logic [31:0]     w_rd_reg;
    logic [31:0]     pre_rd_reg, post_rd_reg;

    logic [CW-1:0] pre_cnt, post_cnt;
    assign pre_cnt  = cnt_vld_rd_reg ? cnt_rd_reg[CW-1:0]    : '0;
    assign post_cnt = cnt_vld_rd_reg ? cnt_rd_reg[2*CW-1:CW] : '0;

    logic          spike_ok;
    logic [CW-1:0] push_cnt;
    logic          is_pre;
    assign is_pre   = (kind_reg == KIND_PRE);
    assign push_cnt = is_pre ? pre_cnt : post_cnt;
    assign spike_ok = (push_cnt < lim);

    logic [2*CW-1:0] cnt_wdata;
    logic            cnt_we;
    always_comb begin
        cnt_we    = cmd.spike_wr | cmd.finish;
        cnt_wdata = '0;
        if (cmd.spike_wr) begin
            cnt_wdata = is_pre ? {post_cnt, pre_cnt + CW'(1)}
                               : {post_cnt + CW'(1), pre_cnt};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_vld_reg <= '0;
        end else if (cnt_we) begin
            cnt_vld_reg[syn_idx] <= 1'b1;
        end
    end

    // Pair walk indexes.
    logic [QW-1:0] i_reg, j_reg;

    always_ff @(posedge aclk) begin
        if (cnt_we) begin
            cnt_mem[syn_idx] <= cnt_wdata;
        end
        if (cmd.rd) begin
            cnt_rd_reg     <= cnt_mem[syn_idx];
            cnt_vld_rd_reg <= cnt_vld_reg[syn_idx];
            w_rd_reg       <= w_mem[syn_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.spike_wr && is_pre) begin
            pre_mem[{syn_idx, push_cnt[QW-1:0]}] <= time_reg;
        end
        if (cmd.pair_rd) begin
            pre_rd_reg <= pre_mem[{syn_idx, i_reg}];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.spike_wr && !is_pre) begin
            post_mem[{syn_idx, push_cnt[QW-1:0]}] <= time_reg;
        end
        if (cmd.pair_rd) begin
            post_rd_reg <= post_mem[{syn_idx, j_reg}];
        end
    end

    logic last_i, last_j;
    assign last_j = ((CW'(j_reg) + CW'(1)) == post_cnt);
    assign last_i = ((CW'(i_reg) + CW'(1)) == pre_cnt);

    always_ff @(posedge aclk) begin
        if (cmd.pair_init) begin
            i_reg <= '0;
            j_reg <= '0;
        end else if (cmd.acc) begin
            if (last_j) begin
                j_reg <= '0;
                i_reg <= i_reg + QW'(1);
            end else begin
                j_reg <= j_reg + QW'(1);
            end
        end
    end

    // Square-and-multiply power unit, one exponent bit per cycle.
    logic signed [32:0] diff;
    logic               diff_pos;
    logic [32:0]        diff_neg;
    assign diff     = $signed({1'b0, post_rd_reg}) - $signed({1'b0, pre_rd_reg});
    assign diff_pos = (diff > 33'sd0);
    assign diff_neg = 33'd0 - diff;

    logic [16:0]        r_reg;
    logic [15:0]        b_reg;
    logic [31:0]        n_reg;
    logic               pos_reg;
    logic [32:0]        rb_prod;
    logic [31:0]        bb_prod;
    assign rb_prod = 33'(r_reg) * 33'(b_reg) + 33'd32768;
    assign bb_prod = 32'(b_reg) * 32'(b_reg) + 32'd32768;

    always_ff @(posedge aclk) begin
        if (cmd.pow_init) begin
            r_reg   <= 17'd65536;
            b_reg   <= diff_pos ? decay_plus_reg : decay_minus_reg;
            n_reg   <= diff_pos ? diff[31:0] : diff_neg[31:0];
            pos_reg <= diff_pos;
        end else if (cmd.pow_step) begin
            if (n_reg[0]) begin
                r_reg <= rb_prod[32:16];
            end
            b_reg <= bb_prod[31:16];
            n_reg <= n_reg >> 1;
        end
    end

    logic signed [33:0]      term_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [15:0]      gain_sel;
    assign gain_sel = pos_reg ? gain_plus_reg : gain_minus_reg;

    always_ff @(posedge aclk) begin
        if (cmd.mul) begin
            term_reg <= gain_sel * $signed({1'b0, r_reg});
        end
        if (cmd.pair_init) begin
            acc_reg <= '0;
        end else if (cmd.acc) begin
            acc_reg <= acc_reg + ACC_W'(term_reg);
        end
    end

    // Q.28 sum to Q16.16 with round half up, then saturating add.
    logic signed [ACC_W-1:0] acc_rnd, delta, w_sum;
    logic                    sat_hi, sat_lo;
    logic [31:0]             w_new;
    assign acc_rnd = acc_reg + ACC_W'(2048);
    assign delta   = acc_rnd >>> 12;
    assign w_sum   = ACC_W'($signed(w_rd_reg)) + delta;
    assign sat_hi  = (w_sum > ACC_W'(32'sh7FFF_FFFF));
    assign sat_lo  = (w_sum < ACC_W'(-64'sh8000_0000));
    assign w_new   = sat_hi ? 32'h7FFF_FFFF : (sat_lo ? 32'h8000_0000 : w_sum[31:0]);

    always_ff @(posedge aclk) begin
        if (cmd.load_wr) begin
            w_mem[syn_idx] <= win_reg;
        end else if (cmd.finish) begin
            w_mem[syn_idx] <= w_new;
        end
    end

    // Result register and output stage.
    logic [31:0] res_w_reg;
    logic        res_applied_reg, res_stored_reg, res_sat_reg;

    always_ff @(posedge aclk) begin
        if (cmd.decide) begin
            res_w_reg       <= !in_range ? 32'd0 :
                               (kind_reg == KIND_LOAD) ? win_reg : w_rd_reg;
            res_applied_reg <= 1'b0;
            res_sat_reg     <= 1'b0;
            res_stored_reg  <= in_range && (kind_reg == KIND_PRE || kind_reg == KIND_POST)
                               && spike_ok;
        end else if (cmd.finish) begin
            res_w_reg       <= w_new;
            res_applied_reg <= 1'b1;
            res_sat_reg     <= sat_hi | sat_lo;
        end
    end

    logic        m_tvalid_reg;
    logic [39:0] m_tdata_reg;
    logic [2:0]  m_tuser_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_tdata_reg <= {res_w_reg, syn_reg};
            m_tuser_reg <= {res_sat_reg, res_stored_reg, res_applied_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    assign status.kind        = kind_reg;
    assign status.in_range    = in_range;
    assign status.spike_ok    = spike_ok;
    assign status.both_full   = (pre_cnt >= lim) && (post_cnt >= lim);
    assign status.pairs_empty = (pre_cnt == '0) || (post_cnt == '0);
    assign status.pow_done    = (n_reg == 32'd0);
    assign status.last_pair   = last_i && last_j;
    assign status.out_free    = !m_tvalid_reg || m_tready;

endmodule

>>> hdl/additive_stdp_weight_update_top.sv
// Additive pair-based STDP engine over a table of synapses. Pre spike, post spike and
// weight-load beats pass from acceptance through the read, decide and emit states; the
// read state holds the registered reads of the count and weight memories. An apply
// beat on a synapse whose two queues are full walks every (pre, post) pair through one
// shared square-and-multiply unit, which steps once per significant bit of the pair's
// time difference; each pair is read, raised to its power, multiplied and accumulated
// while input is held off. A finished result sits in the output register, so the next
// beat is taken while it waits. There is no clearing pass after reset.
module additive_stdp_weight_update_top
    import stdp_pkg::*;
#(
    parameter int SYNAPSES  = 256,
    parameter int MAX_QUEUE = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // synapse[7:0], spike_time[39:8], weight_in[71:40]
    input  logic [71:0] s_tdata,
    // kind[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // synapse_out[7:0], weight_out[39:8]
    output logic [39:0] m_tdata,
    // rule_applied[0], spike_stored[1], saturated[2]
    output logic [2:0]  m_tuser,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    stdp_cmd_t    cmd;
    stdp_status_t status;

    stdp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    stdp_dp #(
        .SYNAPSES  (SYNAPSES),
        .MAX_QUEUE (MAX_QUEUE)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

>>> hdl/stdp_checker.sv
module stdp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic [2:0]  m_tuser
);

    // A stalled result beat keeps its contents.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // One beat is worked on at a time.
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a beat is in flight");

    // An applied rule never also reports a stored spike.
    a_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("rule_applied and spike_stored both set");

    // Saturation only comes from a weight update.
    a_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[2] |-> m_tuser[0])
        else $error("saturated without rule_applied");

endmodule

bind additive_stdp_weight_update_top stdp_checker u_stdp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

>>> verif/additive_stdp_weight_update_top_tb.sv
module additive_stdp_weight_update_top_tb
    import stdp_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSYN = 256;
    localparam int QMAX = 64;

    typedef struct {
        logic [7:0]  syn;
        logic [31:0] weight;
        logic        applied;
        logic        stored;
        logic        sat;
    } syn_result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    additive_stdp_weight_update_top u_dut (.*);

    // Shadow copy of the synapse table and of the registers.
    logic [31:0]      pre_times  [NSYN][QMAX];
    logic [31:0]      post_times [NSYN][QMAX];
    int unsigned      pre_cnt  [NSYN];
    int unsigned      post_cnt [NSYN];
    logic signed [31:0] syn_weight [NSYN];
    bit               loaded [NSYN];
    logic [5:0]       tau_p, tau_m;
    logic [15:0]      decay_p, decay_m;
    logic signed [15:0] gain_p, gain_m;

    syn_result_t pending_results[$];
    int          errors;
    bit          idle_en;
    int          rand_items;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #40ms;
        $display("Regression FAIL");
        $finish;
    end

    function automatic int unsigned queue_limit();
        int unsigned lim;
        lim = tau_p + tau_m;
        return (lim > QMAX) ? QMAX : lim;
    endfunction

    // decay^n by square-and-multiply, Q0.16 with 1.0 = 65536
    function automatic longint unsigned decay_power(logic [15:0] dec, logic [31:0] n);
        longint unsigned r, b;
        r = 65536;
        b = dec;
        for (int i = 0; i < 32; i++) begin
            if (n[i]) r = (r * b + 32768) >> 16;
            b = (b * b + 32768) >> 16;
        end
        return r;
    endfunction

    function automatic void predict_weight_update(logic [1:0] kind, logic [7:0] syn,
                                                  logic [31:0] stamp, logic [31:0] w);
        syn_result_t r;
        longint      sum, d, nw;
        int unsigned lim;
        lim = queue_limit();
        r.syn = syn;
        r.applied = 1'b0;
        r.stored = 1'b0;
        r.sat = 1'b0;
        case (kind)
            KIND_PRE: begin
                if (pre_cnt[syn] < lim) begin
                    pre_times[syn][pre_cnt[syn]] = stamp;
                    pre_cnt[syn]++;
                    r.stored = 1'b1;
                end
            end
            KIND_POST: begin
                if (post_cnt[syn] < lim) begin
                    post_times[syn][post_cnt[syn]] = stamp;
                    post_cnt[syn]++;
                    r.stored = 1'b1;
                end
            end
            KIND_APPLY: begin
                if (pre_cnt[syn] >= lim && post_cnt[syn] >= lim) begin
                    sum = 0;
                    for (int i = 0; i < pre_cnt[syn]; i++)
                        for (int j = 0; j < post_cnt[syn]; j++) begin
                            d = longint'(post_times[syn][j]) - longint'(pre_times[syn][i]);
                            if (d > 0)
                                sum += longint'(gain_p)
                                       * longint'(decay_power(decay_p, d[31:0]));
                            else
                                sum += longint'(gain_m)
                                       * longint'(decay_power(decay_m, 32'(-d)));
                        end
                    nw = longint'(syn_weight[syn]) + ((sum + 2048) >>> 12);
                    if (nw > 64'sh7FFFFFFF) begin
                        nw = 64'sh7FFFFFFF;
                        r.sat = 1'b1;
                    end
                    if (nw < -64'sh80000000) begin
                        nw = -64'sh80000000;
                        r.sat = 1'b1;
                    end
                    syn_weight[syn] = nw[31:0];
                    pre_cnt[syn] = 0;
                    post_cnt[syn] = 0;
                    r.applied = 1'b1;
                end
            end
            default: begin
                syn_weight[syn] = w;
                loaded[syn] = 1'b1;
            end
        endcase
        r.weight = syn_weight[syn];
        pending_results.insert(pending_results.size(), r);
    endfunction

    task automatic send_item(logic [1:0] kind, logic [7:0] syn, logic [31:0] stamp,
                             logic [31:0] w);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = kind;
        s_tdata  = {w, stamp, syn};
        do @(posedge aclk); while (!s_tready);
        predict_weight_update(kind, syn, stamp, w);
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_TAU_PLUS:    tau_p   = val[5:0];
            CFG_TAU_MINUS:   tau_m   = val[5:0];
            CFG_DECAY_PLUS:  decay_p = val;
            CFG_DECAY_MINUS: decay_m = val;
            CFG_GAIN_PLUS:   gain_p  = val;
            CFG_GAIN_MINUS:  gain_m  = val;
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic drain_results();
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic set_params(logic [5:0] tp, logic [5:0] tm, logic [15:0] dp,
                              logic [15:0] dm, logic [15:0] gp, logic [15:0] gm);
        drain_results();
        write_reg(CFG_TAU_PLUS, {10'd0, tp});
        write_reg(CFG_TAU_MINUS, {10'd0, tm});
        write_reg(CFG_DECAY_PLUS, dp);
        write_reg(CFG_DECAY_MINUS, dm);
        write_reg(CFG_GAIN_PLUS, gp);
        write_reg(CFG_GAIN_MINUS, gm);
    endtask

    // The weight of a synapse is unknown until loaded, and every item reports it.
    task automatic make_loaded(logic [7:0] syn);
        if (!loaded[syn]) send_item(KIND_LOAD, syn, $urandom, $urandom);
    endtask

    // Fill both queues of one synapse up to the limit in random order, then apply.
    task automatic fill_and_apply(logic [7:0] syn, bit wide, int span);
        logic [31:0] base;
        int          np, nq;
        base = $urandom;
        make_loaded(syn);
        np = queue_limit() - pre_cnt[syn];
        nq = queue_limit() - post_cnt[syn];
        while (np > 0 || nq > 0) begin
            if (np > 0 && (nq == 0 || $urandom_range(0, 1) == 0)) begin
                send_item(KIND_PRE, syn, wide ? $urandom : base + $urandom_range(0, span),
                          $urandom);
                np--;
            end else begin
                send_item(KIND_POST, syn, wide ? $urandom : base + $urandom_range(0, span),
                          $urandom);
                nq--;
            end
            rand_items++;
        end
        if ($urandom_range(0, 3) == 0) begin
            send_item($urandom_range(0, 1) ? KIND_PRE : KIND_POST, syn, $urandom, $urandom);
            rand_items++;
        end
        send_item(KIND_APPLY, syn, $urandom, $urandom);
        rand_items++;
    endtask

    task automatic test_defaults();
        send_item(KIND_LOAD, 8'd0, 32'd0, 32'h7FFFFFFF);
        send_item(KIND_LOAD, 8'd255, 32'hFFFFFFFF, 32'h80000000);
        send_item(KIND_PRE, 8'd0, 32'd0, 32'd0);
        send_item(KIND_POST, 8'd255, 32'hFFFFFFFF, 32'hFFFFFFFF);
        // Queues not full: nothing changes.
        send_item(KIND_APPLY, 8'd0, 32'd0, 32'd0);
    endtask

    task automatic test_directed_edges();
        set_params(6'd1, 6'd1, 16'd65535, 16'd0, 16'h7FFF, 16'h8000);
        send_item(KIND_LOAD, 8'd1, 32'd0, 32'h7FFF0000);
        send_item(KIND_PRE, 8'd1, 32'd0, 32'd0);
        send_item(KIND_PRE, 8'd1, 32'hFFFFFFFF, 32'd0);
        send_item(KIND_PRE, 8'd1, 32'd5, 32'd0);          // dropped, queue full
        send_item(KIND_POST, 8'd1, 32'hFFFFFFFF, 32'd0);  // equal times, depression path
        send_item(KIND_APPLY, 8'd1, 32'd0, 32'd0);        // not full yet
        send_item(KIND_POST, 8'd1, 32'd0, 32'd0);
        send_item(KIND_APPLY, 8'd1, 32'd0, 32'd0);
        // Potentiation toward the positive rail.
        set_params(6'd1, 6'd0, 16'd65535, 16'd65535, 16'h7FFF, 16'h7FFF);
        send_item(KIND_PRE, 8'd1, 32'd0, 32'd0);
        send_item(KIND_POST, 8'd1, 32'd1, 32'd0);
        send_item(KIND_APPLY, 8'd1, 32'd0, 32'd0);
        send_item(KIND_LOAD, 8'd2, 32'd0, 32'h80000000);
        send_item(KIND_PRE, 8'd2, 32'd10, 32'd0);
        send_item(KIND_POST, 8'd2, 32'd3, 32'd0);
        send_item(KIND_APPLY, 8'd2, 32'd0, 32'd0);
        // A zero limit stores nothing but always applies.
        set_params(6'd0, 6'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        send_item(KIND_PRE, 8'd2, 32'd1, 32'd0);
        send_item(KIND_POST, 8'd2, 32'd2, 32'd0);
        send_item(KIND_APPLY, 8'd2, 32'd0, 32'd0);
    endtask

    task automatic test_full_queue();
        // Both taus at the top: the limit caps at the queue depth.
        set_params(6'd63, 6'd63, 16'd61565, 16'd30000, 16'h8000, 16'd4096);
        fill_and_apply(8'd3, 1'b0, 6);
        set_params(6'd2, 6'd2, 16'd61565, 16'd61565, 16'd4096, 16'd4096);
        fill_and_apply(8'd4, 1'b1, 0);
    endtask

    task automatic test_random(int target);
        logic [7:0] syn;
        int         stop;
        stop = rand_items + target;
        while (rand_items < stop) begin
            if ($urandom_range(0, 49) == 0)
                set_params(6'($urandom_range(0, 5)), 6'($urandom_range(0, 5)),
                           16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
            syn = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                              : 8'($urandom_range(0, 15));
            make_loaded(syn);
            if ($urandom_range(0, 4) != 0) begin
                if ($urandom_range(0, 9) == 0)
                    send_item(KIND_LOAD, syn, $urandom,
                              $urandom_range(0, 1) ? 32'h7FFF0000 + $urandom_range(0, 65535)
                                                   : 32'h80000000 + $urandom_range(0, 65535));
                fill_and_apply(syn, $urandom_range(0, 7) == 0, int'($urandom_range(0, 40)));
            end else begin
                send_item(2'($urandom_range(0, 3)), syn, $urandom, $urandom);
                rand_items++;
            end
        end
    endtask

    // Result side: random stall bursts on m_tready.
    initial begin
        int stall;
        stall = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall > 0) begin
                m_tready = 1'b0;
                stall--;
            end else begin
                m_tready = 1'b1;
                if (idle_en && $urandom_range(0, 7) == 0) stall = $urandom_range(1, 12);
            end
        end
    end

    always @(posedge aclk) begin
        syn_result_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with no expectation, actual syn %0d weight %h",
                         $realtime, m_tdata[7:0], m_tdata[39:8]);
                errors++;
            end else begin
                e = pending_results.pop_front();
                if (m_tdata[7:0] !== e.syn) begin
                    $display("%0t: synapse expected %0d actual %0d",
                             $realtime, e.syn, m_tdata[7:0]);
                    errors++;
                end
                if (m_tdata[39:8] !== e.weight) begin
                    $display("%0t: weight expected %h actual %h",
                             $realtime, e.weight, m_tdata[39:8]);
                    errors++;
                end
                if (m_tuser[0] !== e.applied) begin
                    $display("%0t: rule_applied expected %b actual %b",
                             $realtime, e.applied, m_tuser[0]);
                    errors++;
                end
                if (m_tuser[1] !== e.stored) begin
                    $display("%0t: spike_stored expected %b actual %b",
                             $realtime, e.stored, m_tuser[1]);
                    errors++;
                end
                if (m_tuser[2] !== e.sat) begin
                    $display("%0t: saturated expected %b actual %b",
                             $realtime, e.sat, m_tuser[2]);
                    errors++;
                end
            end
        end
    end

    initial begin
        errors     = 0;
        rand_items = 0;
        idle_en    = 1'b1;
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = KIND_PRE;
        cfg_valid  = 1'b0;
        cfg_index  = CFG_TAU_PLUS;
        cfg_data   = '0;
        tau_p   = TAU_RESET;
        tau_m   = TAU_RESET;
        decay_p = DECAY_RESET;
        decay_m = DECAY_RESET;
        gain_p  = GAIN_RESET;
        gain_m  = GAIN_RESET;
        for (int i = 0; i < NSYN; i++) begin
            pre_cnt[i]    = 0;
            post_cnt[i]   = 0;
            syn_weight[i] = '0;
            loaded[i]     = 1'b0;
        end
        repeat (3) @(negedge aclk);
        aresetn = 1'b1;

        test_defaults();
        test_directed_edges();
        test_full_queue();
        set_params(6'd3, 6'd2, 16'($urandom), 16'($urandom), 16'($urandom),
                   16'($urandom));
        test_random(600);
        drain_results();
        // Last stretch runs back to back on both sides.
        idle_en = 1'b0;
        test_random(150);

        drain_results();
        repeat (50) @(negedge aclk);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
